// ----- rtl/mrsp_pkg.sv -----
// Shared types, constants and the status length table for the MIDI running status parser.
// No dependencies; every other file imports this package.
`default_nettype none

package mrsp_pkg;

    localparam int NUM_PORTS   = 2;
    localparam int PORT_W      = 1;
    localparam int NUM_EV      = 3;
    localparam int EV_CNT_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam logic [7:0] OPEN_LENGTH = 8'd255;
    localparam logic [7:0] RT_FIRST    = 8'hF8;

    localparam logic [1:0] EV_START    = 2'd0;
    localparam logic [1:0] EV_DATA     = 2'd1;
    localparam logic [1:0] EV_END      = 2'd2;
    localparam logic [1:0] EV_REALTIME = 2'd3;

    typedef struct packed {
        logic [PORT_W-1:0] src_port;
        logic [1:0]        event_kind;
        logic [7:0]        value;
        logic              by_running_status;
        logic              is_raw;
        logic              complete;
    } evt_t;

    // all events caused by one byte, in order
    typedef struct packed {
        evt_t [NUM_EV-1:0]   ev;
        logic [EV_CNT_W-1:0] cnt;
    } bundle_t;

    typedef struct packed {
        logic    full;
        logic    empty;
        bundle_t head;
    } queue_stat_t;

    function automatic logic [7:0] len_for_status(input logic [7:0] s);
        logic [7:0] len;
        begin
            len = 8'd0;
            case (s[7:4]) inside
                4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 8'd2;
                4'hC, 4'hD:                    len = 8'd1;
                4'hF:
                begin
                    case (s[3:0]) inside
                        4'h0:       len = OPEN_LENGTH;
                        4'h1, 4'h3: len = 8'd1;
                        4'h2:       len = 8'd2;
                        default:    len = 8'd0;
                    endcase
                end
                default: len = 8'd0;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mrsp_in_if.sv -----
// Input byte channel: valid/ready handshake with port tag and byte.
// Depends on mrsp_pkg.
`default_nettype none

interface mrsp_in_if
    import mrsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] port;
    logic [7:0]        byte_in;

    modport source (output valid, output port, output byte_in, input ready);
    modport sink   (input valid, input port, input byte_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/mrsp_out_if.sv -----
// Output event channel: valid/ready handshake with one parsed event.
// Depends on mrsp_pkg.
`default_nettype none

interface mrsp_out_if
    import mrsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] src_port;
    logic [1:0]        event_kind;
    logic [7:0]        value;
    logic              by_running_status;
    logic              is_raw;
    logic              complete;
    logic              last;

    modport source (output valid, output src_port, output event_kind, output value,
                    output by_running_status, output is_raw, output complete,
                    output last, input ready);
    modport sink   (input valid, input src_port, input event_kind, input value,
                    input by_running_status, input is_raw, input complete,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/midi_running_status_parser_top.sv -----
// Top level of the MIDI running status parser: front end, bundle queue, back end.
// Depends on mrsp_pkg, mrsp_in_if, mrsp_out_if, mrsp_front, mrsp_queue, mrsp_back.
//
//  channel | dir | payload
//  in_ch   | in  | port, byte_in
//  out_ch  | out | src_port, event_kind, value, by_running_status, is_raw, complete, last
//
// A byte is taken whenever the two-entry queue has room; its one to three
// events leave the output register one per cycle while out_ch is ready, so the back end,
// which emits every event of a byte in turn, sets the sustained rate.
// Reset clears the receiving and running-status flags of every port; no clearing pass.
// Input and output stall independently; a stalled output fills the queue, then drops ready.
`default_nettype none

module midi_running_status_parser_top
    import mrsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mrsp_in_if.sink    in_ch,
    mrsp_out_if.source out_ch
);

    logic        queue_full;
    logic        push;
    bundle_t     push_data;
    logic        pop;
    queue_stat_t stat;
    evt_t        out_evt;

    assign queue_full = stat.full;

    mrsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_port    (in_ch.port),
        .in_byte    (in_ch.byte_in),
        .queue_full (queue_full),
        .in_ready   (in_ch.ready),
        .push       (push),
        .push_data  (push_data)
    );

    mrsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .stat      (stat)
    );

    mrsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .out_ready (out_ch.ready),
        .pop       (pop),
        .out_valid (out_ch.valid),
        .out_evt   (out_evt),
        .out_last  (out_ch.last)
    );

    assign out_ch.src_port          = out_evt.src_port;
    assign out_ch.event_kind        = out_evt.event_kind;
    assign out_ch.value             = out_evt.value;
    assign out_ch.by_running_status = out_evt.by_running_status;
    assign out_ch.is_raw            = out_evt.is_raw;
    assign out_ch.complete          = out_evt.complete;

endmodule

`default_nettype wire

// ----- rtl/mrsp_front.sv -----
// Front end: accepts bytes, keeps per-port parse state, emits one event bundle per byte.
// Depends on mrsp_pkg.
`default_nettype none

module mrsp_front
    import mrsp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [PORT_W-1:0] in_port,
    input  wire logic [7:0]        in_byte,
    input  wire logic              queue_full,
    output      logic              in_ready,
    output      logic              push,
    output      bundle_t           push_data
);

    logic [NUM_PORTS-1:0] receiving_reg, receiving_next;
    logic [NUM_PORTS-1:0] running_ok_reg, running_ok_next;
    logic [7:0]           data_count_reg     [NUM_PORTS];
    logic [7:0]           expected_count_reg [NUM_PORTS];
    logic [7:0]           last_status_reg    [NUM_PORTS];

    logic                accept;
    logic                port_ok;
    logic                is_status;
    logic                is_rt;
    logic                cont;
    logic                end0;
    logic                open_after;
    logic                dat;
    logic                end_d;
    logic                upd;
    logic [7:0]          new_exp;
    logic [7:0]          base_cnt;
    logic [7:0]          base_exp;
    logic [7:0]          cnt_inc;
    logic [EV_CNT_W-1:0] n;
    evt_t                blank;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        port_ok   = int'(in_port) < NUM_PORTS;
        is_status = in_byte[7];
        is_rt     = in_byte >= RT_FIRST;
        cont      = receiving_reg[in_port] && !is_status;

        if (is_status)
        begin
            new_exp = len_for_status(in_byte);
        end
        else if (running_ok_reg[in_port])
        begin
            new_exp = len_for_status(last_status_reg[in_port]);
        end
        else
        begin
            new_exp = OPEN_LENGTH;
        end

        base_cnt   = cont ? data_count_reg[in_port] : 8'd0;
        base_exp   = cont ? expected_count_reg[in_port] : new_exp;
        end0       = !cont && (new_exp == 8'd0);
        open_after = cont || !end0;
        dat        = !is_status && open_after;
        cnt_inc    = base_cnt + 8'd1;
        end_d      = dat && (base_exp == cnt_inc);
        upd        = accept && port_ok && !is_rt;

        blank                   = '0;
        blank.src_port          = in_port;
        push_data               = '0;
        n                       = '0;

        if (is_rt)
        begin
            push_data.ev[n]            = blank;
            push_data.ev[n].event_kind = EV_REALTIME;
            push_data.ev[n].value      = in_byte;
            n                          = n + 1'b1;
        end
        else
        begin
            // status cuts an open message short
            if (receiving_reg[in_port] && is_status)
            begin
                push_data.ev[n]            = blank;
                push_data.ev[n].event_kind = EV_END;
                n                          = n + 1'b1;
            end
            if (!cont)
            begin
                push_data.ev[n]            = blank;
                push_data.ev[n].event_kind = EV_START;
                if (is_status)
                begin
                    push_data.ev[n].value = in_byte;
                end
                else if (running_ok_reg[in_port])
                begin
                    push_data.ev[n].value             = last_status_reg[in_port];
                    push_data.ev[n].by_running_status = 1'b1;
                end
                else
                begin
                    push_data.ev[n].is_raw = 1'b1;
                end
                n = n + 1'b1;
                if (end0)
                begin
                    push_data.ev[n]            = blank;
                    push_data.ev[n].event_kind = EV_END;
                    push_data.ev[n].complete   = 1'b1;
                    n                          = n + 1'b1;
                end
            end
            if (dat)
            begin
                push_data.ev[n]            = blank;
                push_data.ev[n].event_kind = EV_DATA;
                push_data.ev[n].value      = in_byte;
                n                          = n + 1'b1;
                if (end_d)
                begin
                    push_data.ev[n]            = blank;
                    push_data.ev[n].event_kind = EV_END;
                    push_data.ev[n].complete   = 1'b1;
                    n                          = n + 1'b1;
                end
            end
        end
        push_data.cnt = n;
        push          = accept && port_ok && (n != '0);

        receiving_next  = receiving_reg;
        running_ok_next = running_ok_reg;
        if (upd)
        begin
            receiving_next[in_port] = open_after && !end_d;
            if (!cont && is_status)
            begin
                running_ok_next[in_port] = (in_byte >= 8'h80) && (in_byte <= 8'hEF);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg  <= '0;
            running_ok_reg <= '0;
        end
        else
        begin
            receiving_reg  <= receiving_next;
            running_ok_reg <= running_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            data_count_reg[in_port] <= dat ? cnt_inc : base_cnt;
            if (!cont)
            begin
                expected_count_reg[in_port] <= base_exp;
                if (is_status)
                begin
                    last_status_reg[in_port] <= in_byte;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mrsp_queue.sv -----
// Two-entry bundle queue between front end and back end.
// Depends on mrsp_pkg.
`default_nettype none

module mrsp_queue
    import mrsp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t push_data,
    input  wire logic    pop,
    output queue_stat_t  stat
);

    bundle_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        stat.full   = count_reg == QCNT_W'(QUEUE_DEPTH);
        stat.empty  = count_reg == '0;
        stat.head   = entry_reg[rd_ptr_reg];
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mrsp_back.sv -----
// Back end: walks the head bundle one event per cycle, whenever the output register is free, into that register.
// Depends on mrsp_pkg.
`default_nettype none

module mrsp_back
    import mrsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire queue_stat_t stat,
    input  wire logic        out_ready,
    output      logic        pop,
    output      logic        out_valid,
    output      evt_t        out_evt,
    output      logic        out_last
);

    logic [EV_CNT_W-1:0] idx_reg, idx_next;
    logic                valid_reg, valid_next;
    evt_t                evt_reg, evt_next;
    logic                last_reg, last_next;
    logic                load;
    logic                is_last;

    always_comb
    begin
        load       = (!valid_reg || out_ready) && !stat.empty;
        is_last    = idx_reg == (stat.head.cnt - 1'b1);
        pop        = load && is_last;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        evt_next   = evt_reg;
        last_next  = last_reg;
        if (load)
        begin
            evt_next   = stat.head.ev[idx_reg];
            last_next  = is_last;
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        evt_reg  <= evt_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_evt   = evt_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire
